// ===== hw/rtl/pfa_pkg.sv =====
// Shared types and constants of the paged frame allocator.
// Used by pfa_free_fifo and paged_frame_allocator; depends on nothing.
`default_nettype none

package pfa_pkg;

    // Default sizing of the block
    localparam int MEMORY_BYTES_DEF      = 16;
    localparam int FRAME_BYTES_DEF       = 2;
    localparam int MAX_PROCESS_BYTES_DEF = 4;

    // Fixed shift of the reciprocal used for bytes / frame size
    localparam int DIV_SHIFT = 17;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_VIEW   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_NO_FRAMES  = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_SLOTS_FULL = 3'd4
    } t_status;

    // Request to the free frame queue; at most one bit set per cycle
    typedef struct packed {
        logic init;
        logic pop;
        logic push;
    } t_fifo_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/pfa_free_fifo.sv =====
// Circular queue of free frame addresses, held in a one-port-read synchronous memory.
// Depends on pfa_pkg for the command struct.
`default_nettype none

module pfa_free_fifo #(
    parameter int MEMORY_BYTES = 16,
    parameter int FRAME_BYTES  = 2,
    parameter int FA_W         = 4,
    parameter int CNT_W        = 4,
    parameter int IDX_W        = 3
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire pfa_pkg::t_fifo_cmd i_cmd,
    input  wire  [IDX_W-1:0]       i_init_idx,
    input  wire  [FA_W-1:0]        i_push_data,
    output logic [FA_W-1:0]        o_pop_data,
    output logic [CNT_W-1:0]       o_count
);
    import pfa_pkg::*;

    localparam int FRAME_COUNT = MEMORY_BYTES / FRAME_BYTES;
    localparam int SUM_W       = $clog2(2 * FRAME_COUNT) + 1;

    logic [FA_W-1:0]  r_mem [FRAME_COUNT];
    logic [FA_W-1:0]  r_rd_q;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;

    logic [SUM_W-1:0] w_sum;
    logic [IDX_W-1:0] w_tail;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [FA_W-1:0]  w_wdata;
    logic             w_full;

    // Tail = (head + count) mod depth; the sum stays below twice the depth
    assign w_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail = (w_sum >= SUM_W'(FRAME_COUNT)) ? IDX_W'(w_sum - SUM_W'(FRAME_COUNT))
                                                   : IDX_W'(w_sum);
    assign w_full = (r_count == CNT_W'(FRAME_COUNT));

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        w_we    = 1'b0;
        w_waddr = w_tail;
        w_wdata = i_push_data;
        if (i_cmd.init) begin
            w_we    = 1'b1;
            w_waddr = i_init_idx;
            w_wdata = FA_W'(int'(i_init_idx) * FRAME_BYTES);
        end else if (i_cmd.pop) begin
            n_head  = (r_head == IDX_W'(FRAME_COUNT - 1)) ? '0 : IDX_W'(r_head + 1'b1);
            n_count = CNT_W'(r_count - 1'b1);
        end else if (i_cmd.push && !w_full) begin
            // drop a push into a full queue
            w_we    = 1'b1;
            n_count = CNT_W'(r_count + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= CNT_W'(FRAME_COUNT);
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.pop) begin
            r_rd_q <= r_mem[r_head];
        end
    end

    assign o_pop_data = r_rd_q;
    assign o_count    = r_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_COUNT))
        else $error("free frame count above frame total");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("pop from empty free frame queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop && !i_cmd.init) |=> r_count == CNT_W'($past(r_count) - 1'b1))
        else $error("pop did not lower the free count");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/paged_frame_allocator.sv =====
// Top level of the paged frame allocator: slot table, page table memory and control.
// Depends on pfa_pkg and pfa_free_fifo.
//
// Usage:
//   Command channel: drive i_action, i_process_id and i_process_bytes with start high;
//   the item is taken on a rising edge where start is high and busy is low.
//   Result channel: each result sits on the o_* ports for one cycle, marked by
//   o_result_valid; the receiver cannot hold results off, so nothing stalls here.
//   A view item that finds pages gives one result per page, with o_last on the final one; every
//   other item gives exactly one result.
// Flow: a too-long create or an unused action answers in the cycle after accept.
//   Everything else first scans the slot table, one entry per cycle out of the
//   slot memory, then on a hit walks the pages through the page memory and free
//   frame queue, with a read and then a write or emit for each page.
//   The last result shows as busy drops.
// Reset: a sweep over all FRAME_COUNT frames (8 by default) fills the free frame queue
//   with frame addresses in ascending order and clears every slot valid bit;
//   busy stays high until it completes.
// Only one item is in flight, so no memory entry is read and written by overlapping
//   items: the busy handshake is the interlock.
`default_nettype none

module paged_frame_allocator #(
    parameter int MEMORY_BYTES      = pfa_pkg::MEMORY_BYTES_DEF,
    parameter int FRAME_BYTES       = pfa_pkg::FRAME_BYTES_DEF,
    parameter int MAX_PROCESS_BYTES = pfa_pkg::MAX_PROCESS_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_action,
    input  wire  [7:0]  i_process_id,
    input  wire  [7:0]  i_process_bytes,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic        o_entry_valid,
    output logic        o_page_index,
    output logic [3:0]  o_frame_address,
    output logic [2:0]  o_stored_bytes,
    output logic        o_last
);
    import pfa_pkg::*;

    // Sizing
    localparam int FRAME_COUNT = MEMORY_BYTES / FRAME_BYTES;
    localparam int SLOT_COUNT  = FRAME_COUNT;
    localparam int PAGES       = MAX_PROCESS_BYTES / FRAME_BYTES;
    localparam int PAGES_ST    = (PAGES > 0) ? PAGES : 1;
    localparam int FA_W        = $clog2(MEMORY_BYTES);
    localparam int SI_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
    localparam int PC_W        = $clog2(PAGES_ST + 1);
    localparam int BW          = $clog2(MAX_PROCESS_BYTES + 1);
    localparam int PT_DEPTH    = SLOT_COUNT * PAGES_ST;
    localparam int PI_W        = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    // Reciprocal of the frame size: exact quotient for any 8-bit byte count
    localparam int RECIP       = ((2 ** DIV_SHIFT) + FRAME_BYTES - 1) / FRAME_BYTES;
    localparam int PROD_W      = 8 + DIV_SHIFT + 1;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_C_POP = 9'b000001000,
        S_C_WR  = 9'b000010000,
        S_F_RD  = 9'b000100000,
        S_F_WR  = 9'b001000000,
        S_V_RD  = 9'b010000000,
        S_V_OUT = 9'b100000000
    } t_state;

    // Control registers
    t_state          r_state, n_state;
    logic [SI_W-1:0] r_ptr, n_ptr;
    logic [SI_W-1:0] r_dptr, n_dptr;
    logic            r_pend, n_pend;
    logic            r_issued, n_issued;
    t_action         r_action, n_action;
    logic [7:0]      r_id, n_id;
    logic [BW-1:0]   r_len, n_len;
    logic [PC_W-1:0] r_pages, n_pages;
    logic [SI_W-1:0] r_slot, n_slot;
    logic [PC_W-1:0] r_p, n_p;

    // Result register
    logic            r_res_vld, n_res_vld;
    t_status         r_res_status, n_res_status;
    logic            r_res_entry, n_res_entry;
    logic            r_res_page, n_res_page;
    logic [FA_W-1:0] r_res_frame, n_res_frame;
    logic [BW-1:0]   r_res_bytes, n_res_bytes;
    logic            r_res_last, n_res_last;

    // Slot table memory: valid, id, byte length, page count per slot
    logic            r_sv     [SLOT_COUNT];
    logic [7:0]      r_sid    [SLOT_COUNT];
    logic [BW-1:0]   r_sbytes [SLOT_COUNT];
    logic [PC_W-1:0] r_spages [SLOT_COUNT];
    logic            r_sq_valid;
    logic [7:0]      r_sq_id;
    logic [BW-1:0]   r_sq_bytes;
    logic [PC_W-1:0] r_sq_pages;

    logic            w_slot_re;
    logic            w_slot_we;
    logic [SI_W-1:0] w_slot_waddr;
    logic            w_slot_wvalid;
    logic [7:0]      w_slot_wid;
    logic [BW-1:0]   w_slot_wbytes;
    logic [PC_W-1:0] w_slot_wpages;

    // Page table memory, PAGES_ST entries per slot
    logic [FA_W-1:0] r_pt [PT_DEPTH];
    logic [FA_W-1:0] r_pt_q;
    logic            w_pt_re;
    logic            w_pt_we;
    logic [PI_W-1:0] w_pt_addr;

    // Free frame queue
    t_fifo_cmd        w_fcmd;
    logic [FA_W-1:0]  w_pop_data;
    logic [CNT_W-1:0] w_free_count;

    logic [PROD_W-1:0] w_prod;
    logic              w_too_long;
    logic              w_hit;
    logic              w_last_page;

    pfa_free_fifo #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .FRAME_BYTES  (FRAME_BYTES),
        .FA_W         (FA_W),
        .CNT_W        (CNT_W),
        .IDX_W        (SI_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_fcmd),
        .i_init_idx  (r_ptr),
        .i_push_data (r_pt_q),
        .o_pop_data  (w_pop_data),
        .o_count     (w_free_count)
    );

    // Page count of a create: bytes / frame size by reciprocal multiply
    assign w_prod     = PROD_W'(i_process_bytes) * PROD_W'(RECIP);
    assign w_too_long = (32'(i_process_bytes) > MAX_PROCESS_BYTES);

    // Create looks for the lowest free slot, free and view for the lowest slot with a matching id
    assign w_hit = r_pend && ((r_action == ACT_CREATE) ? !r_sq_valid
                                                       : (r_sq_valid && (r_sq_id == r_id)));
    assign w_last_page = (PC_W'(r_p + 1'b1) == r_pages);
    assign w_pt_addr   = PI_W'(int'(r_slot) * PAGES_ST + int'(r_p));

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_dptr       = r_dptr;
        n_pend       = 1'b0;
        n_issued     = r_issued;
        n_action     = r_action;
        n_id         = r_id;
        n_len        = r_len;
        n_pages      = r_pages;
        n_slot       = r_slot;
        n_p          = r_p;
        n_res_vld    = 1'b0;
        n_res_status = ST_OK;
        n_res_entry  = 1'b0;
        n_res_page   = 1'b0;
        n_res_frame  = '0;
        n_res_bytes  = '0;
        n_res_last   = 1'b1;

        w_slot_re     = 1'b0;
        w_slot_we     = 1'b0;
        w_slot_waddr  = r_dptr;
        w_slot_wvalid = 1'b0;
        w_slot_wid    = r_id;
        w_slot_wbytes = r_len;
        w_slot_wpages = r_pages;
        w_pt_re       = 1'b0;
        w_pt_we       = 1'b0;
        w_fcmd        = '0;

        case (r_state)
            S_INIT: begin
                // sweep: load the free queue and clear slot valid bits
                w_fcmd.init   = 1'b1;
                w_slot_we     = 1'b1;
                w_slot_waddr  = r_ptr;
                w_slot_wvalid = 1'b0;
                if (r_ptr == SI_W'(SLOT_COUNT - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = SI_W'(r_ptr + 1'b1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_action = t_action'(i_action);
                    n_id     = i_process_id;
                    n_len    = BW'(i_process_bytes);
                    n_pages  = PC_W'(w_prod >> DIV_SHIFT);
                    n_ptr    = '0;
                    n_issued = 1'b0;
                    case (t_action'(i_action))
                        ACT_CREATE: begin
                            if (w_too_long) begin
                                n_res_vld    = 1'b1;
                                n_res_status = ST_TOO_LONG;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_FREE, ACT_VIEW: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_res_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one slot read per cycle, examine the one read last cycle
                if (!r_issued) begin
                    w_slot_re = 1'b1;
                    n_dptr    = r_ptr;
                    n_pend    = 1'b1;
                    if (r_ptr == SI_W'(SLOT_COUNT - 1)) begin
                        n_issued = 1'b1;
                    end else begin
                        n_ptr = SI_W'(r_ptr + 1'b1);
                    end
                end
                if (w_hit) begin
                    n_slot = r_dptr;
                    n_p    = '0;
                    case (r_action)
                        ACT_CREATE: begin
                            if (32'(r_pages) > 32'(w_free_count)) begin
                                n_res_vld    = 1'b1;
                                n_res_status = ST_NO_FRAMES;
                                n_state      = S_IDLE;
                            end else begin
                                w_slot_we     = 1'b1;
                                w_slot_wvalid = 1'b1;
                                if (r_pages == '0) begin
                                    n_res_vld = 1'b1;
                                    n_state   = S_IDLE;
                                end else begin
                                    n_state = S_C_POP;
                                end
                            end
                        end
                        ACT_FREE: begin
                            w_slot_we     = 1'b1;
                            w_slot_wvalid = 1'b0;
                            w_slot_wid    = r_sq_id;
                            w_slot_wbytes = r_sq_bytes;
                            w_slot_wpages = r_sq_pages;
                            n_pages       = r_sq_pages;
                            if (r_sq_pages == '0) begin
                                n_res_vld = 1'b1;
                                n_state   = S_IDLE;
                            end else begin
                                n_state = S_F_RD;
                            end
                        end
                        default: begin
                            n_pages = r_sq_pages;
                            n_len   = r_sq_bytes;
                            if (r_sq_pages == '0) begin
                                n_res_vld   = 1'b1;
                                n_res_bytes = r_sq_bytes;
                                n_state     = S_IDLE;
                            end else begin
                                n_state = S_V_RD;
                            end
                        end
                    endcase
                end else if (r_pend && r_dptr == SI_W'(SLOT_COUNT - 1)) begin
                    n_res_vld    = 1'b1;
                    n_res_status = (r_action == ACT_CREATE) ? ST_SLOTS_FULL : ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end
            end
            S_C_POP: begin
                w_fcmd.pop = 1'b1;
                n_state    = S_C_WR;
            end
            S_C_WR: begin
                w_pt_we = 1'b1;
                n_p     = PC_W'(r_p + 1'b1);
                if (w_last_page) begin
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_C_POP;
                end
            end
            S_F_RD: begin
                w_pt_re = 1'b1;
                n_state = S_F_WR;
            end
            S_F_WR: begin
                w_fcmd.push = 1'b1;
                n_p         = PC_W'(r_p + 1'b1);
                if (w_last_page) begin
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_V_RD: begin
                w_pt_re = 1'b1;
                n_state = S_V_OUT;
            end
            S_V_OUT: begin
                n_res_vld   = 1'b1;
                n_res_entry = 1'b1;
                n_res_page  = r_p[0];
                n_res_frame = r_pt_q;
                n_res_bytes = r_len;
                n_res_last  = w_last_page;
                n_p         = PC_W'(r_p + 1'b1);
                n_state     = w_last_page ? S_IDLE : S_V_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_pend    <= 1'b0;
            r_issued  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_pend    <= n_pend;
            r_issued  <= n_issued;
            r_res_vld <= n_res_vld;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge i_clk) begin
        r_dptr       <= n_dptr;
        r_action     <= n_action;
        r_id         <= n_id;
        r_len        <= n_len;
        r_pages      <= n_pages;
        r_slot       <= n_slot;
        r_p          <= n_p;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_res_page   <= n_res_page;
        r_res_frame  <= n_res_frame;
        r_res_bytes  <= n_res_bytes;
        r_res_last   <= n_res_last;
    end

    // Slot table memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_sv[w_slot_waddr]     <= w_slot_wvalid;
            r_sid[w_slot_waddr]    <= w_slot_wid;
            r_sbytes[w_slot_waddr] <= w_slot_wbytes;
            r_spages[w_slot_waddr] <= w_slot_wpages;
        end
        if (w_slot_re) begin
            r_sq_valid <= r_sv[r_ptr];
            r_sq_id    <= r_sid[r_ptr];
            r_sq_bytes <= r_sbytes[r_ptr];
            r_sq_pages <= r_spages[r_ptr];
        end
    end

    // Page table memory
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt[w_pt_addr] <= w_pop_data;
        end
        if (w_pt_re) begin
            r_pt_q <= r_pt[w_pt_addr];
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_res_vld;
    assign o_status        = r_res_status;
    assign o_entry_valid   = r_res_entry;
    assign o_page_index    = r_res_page;
    assign o_frame_address = 4'(r_res_frame);
    assign o_stored_bytes  = 3'(r_res_bytes);
    assign o_last          = r_res_last;

`ifndef ASSERT_OFF
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted item neither busy nor answered");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_entry_valid) |-> (o_status == 3'(ST_OK)))
        else $error("page entry reported with error status");

    a_more_only_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> o_entry_valid)
        else $error("non-final result without page entry");
`endif

endmodule

`default_nettype wire
